/* rtl/core/edf_task_scheduler_core_macros.svh */
// Assertion macros used by the scheduler controller RTL.
`ifndef EDF_TASK_SCHEDULER_CORE_MACROS_SVH
`define EDF_TASK_SCHEDULER_CORE_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define EDF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante.
`define EDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/edf_pkg.sv */
// Types and constants shared by the scheduler modules.
`timescale 1ns / 1ps
`default_nettype none
package edf_pkg;
	localparam int unsigned DATA_W = 16;
	localparam int unsigned IDX_IN_W = 4;
	localparam int unsigned TASK_W = 4;
	localparam int unsigned TCNT_W = 4;

	localparam logic [DATA_W-1:0] DEADLINE_LIMIT = 16'd9999;
	localparam logic [TCNT_W-1:0] TASK_COUNT_RESET = 4'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic REG_TASK_COUNT = 1'b0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_en;
		logic scan_start;
		logic rd_en;
		logic wb_en;
	} edf_cmd_t;
endpackage
`default_nettype wire

/* rtl/core/edf_dpath.sv */
// Task table memory, deadline compare and result register.
`timescale 1ns / 1ps
`default_nettype none
module edf_dpath #(
	parameter int unsigned MAX_TASKS = 10,
	parameter int unsigned IDX_W = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire edf_pkg::edf_cmd_t               cmd,
	input  wire logic [IDX_W-1:0]                rd_addr,
	input  wire logic [edf_pkg::IDX_IN_W-1:0]    task_index,
	input  wire logic [edf_pkg::DATA_W-1:0]      exec_time,
	input  wire logic [edf_pkg::DATA_W-1:0]      task_deadline,
	output logic      [edf_pkg::TASK_W-1:0]      running_task
);
	import edf_pkg::*;

	logic [DATA_W-1:0] rem_mem [MAX_TASKS];
	logic [DATA_W-1:0] dl_mem  [MAX_TASKS];
	logic [MAX_TASKS-1:0] ent_vld_q;

	logic [31:0]       ld_wide;
	logic [IDX_W-1:0]  ld_addr;
	logic              ld_ok;

	logic [DATA_W-1:0] rd_rem_s1;
	logic [DATA_W-1:0] rd_dl_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              rd_vld_s1;
	logic              rd_ent_s1;

	logic [DATA_W-1:0] best_dl_q;
	logic [DATA_W-1:0] best_rem_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              found_q;
	logic              hit;
	logic [TASK_W-1:0] running_task_q;

	assign ld_wide = 32'(task_index);
	assign ld_addr = ld_wide[IDX_W-1:0];
	assign ld_ok   = cmd.ld_en && (ld_wide < MAX_TASKS);

	// An entry that was never loaded is masked by its valid bit, and one with zero time never wins.
	assign hit = rd_vld_s1 && rd_ent_s1 && (rd_rem_s1 != '0) && (rd_dl_s1 < best_dl_q);

	always_ff @(posedge clk) begin
		if (ld_ok) begin
			rem_mem[ld_addr] <= exec_time;
			dl_mem[ld_addr]  <= task_deadline;
		end else if (cmd.wb_en && found_q) begin
			rem_mem[best_idx_q] <= best_rem_q - 1'b1;
		end
		if (cmd.rd_en) begin
			rd_rem_s1 <= rem_mem[rd_addr];
			rd_dl_s1  <= dl_mem[rd_addr];
		end
		rd_idx_s1 <= rd_addr;
		if (hit) begin
			best_rem_q <= rd_rem_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (cmd.wb_en) begin
			running_task_q <= found_q ? TASK_W'(32'(best_idx_q) + 32'd1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_ent_s1 <= 1'b0;
			found_q   <= 1'b0;
			best_dl_q <= DEADLINE_LIMIT;
		end else begin
			if (ld_ok) begin
				ent_vld_q[ld_addr] <= 1'b1;
			end
			rd_vld_s1 <= cmd.rd_en;
			rd_ent_s1 <= ent_vld_q[rd_addr];
			if (cmd.scan_start) begin
				found_q   <= 1'b0;
				best_dl_q <= DEADLINE_LIMIT;
			end else if (hit) begin
				found_q   <= 1'b1;
				best_dl_q <= rd_dl_s1;
			end
		end
	end

	assign running_task = running_task_q;
endmodule
`default_nettype wire

/* rtl/core/edf_ctrl.sv */
// Request sequencing: load, table scan, write-back and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module edf_ctrl #(
	parameter int unsigned MAX_TASKS = 10,
	parameter int unsigned IDX_W = 4,
	parameter int unsigned CNT_W = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [edf_pkg::TCNT_W-1:0]    task_count,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output edf_pkg::edf_cmd_t                  cmd,
	output logic      [IDX_W-1:0]              rd_addr
);
	import edf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WB
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [CNT_W-1:0] lim;
	logic             out_valid_q;
	logic             in_take;
	logic             out_free;
	logic             last_idx;

	assign lim      = (32'(task_count) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count);
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign last_idx = (CNT_W'(scan_idx_q + 1'b1) == lim);
	assign rd_addr  = scan_idx_q[IDX_W-1:0];

	assign cmd.ld_en      = in_take && (op == OP_LOAD);
	assign cmd.scan_start = in_take && (op == OP_TICK);
	assign cmd.rd_en      = (state_q == ST_SCAN);
	assign cmd.wb_en      = (state_q == ST_WB) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one leaving in the same cycle.
			if (out_valid_q && !out_stall && !cmd.wb_en) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take && (op == OP_TICK)) begin
						scan_idx_q <= '0;
						state_q    <= (lim == '0) ? ST_WB : ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= CNT_W'(scan_idx_q + 1'b1);
					if (last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The compare of the last entry happens in this cycle.
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`include "edf_task_scheduler_core_macros.svh"

	`EDF_ASSERT_NOW(a_scan_in_range, state_q == ST_SCAN, 32'(scan_idx_q) < 32'(lim),
		"scan index passed the task count")
	`EDF_ASSERT_NEXT(a_tick_busy, in_take && (op == OP_TICK), state_q != ST_IDLE,
		"tick request did not start a scan")
	`EDF_ASSERT_NEXT(a_wb_result, (state_q == ST_WB) && !out_valid_q,
		out_valid_q && (state_q == ST_IDLE), "write-back with a free output gave no result")
endmodule
`default_nettype wire

/* rtl/core/edf_task_scheduler_core.sv */
// Earliest-deadline-first scheduler top level: register port, controller and datapath.
// A load request writes the entry at task_index, if below MAX_TASKS, and gives no result.
// A tick request scans min(task_count, MAX_TASKS) entries, one per memory read cycle,
// then the DRAIN compare state, skipped if none are scanned, and the WB write-back state.
// Reset clears the task table through per-entry valid bits and sets task_count to 1.
`timescale 1ns / 1ps
`default_nettype none
module edf_task_scheduler_core #(
	parameter int unsigned MAX_TASKS = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          op,
	input  wire logic [edf_pkg::IDX_IN_W-1:0]  task_index,
	input  wire logic [edf_pkg::DATA_W-1:0]    exec_time,
	input  wire logic [edf_pkg::DATA_W-1:0]    task_deadline,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [edf_pkg::TASK_W-1:0]    running_task
);
	import edf_pkg::*;

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

	logic [TCNT_W-1:0] task_count_q;
	logic              reg_sel;
	edf_cmd_t          cmd;
	logic [IDX_W-1:0]  rd_addr;

	assign reg_sel = (paddr[2] == REG_TASK_COUNT);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? 32'(task_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= TASK_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			task_count_q <= pwdata[TCNT_W-1:0];
		end
	end

	edf_ctrl #(
		.MAX_TASKS(MAX_TASKS),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.task_count(task_count_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd),
		.rd_addr(rd_addr)
	);

	edf_dpath #(
		.MAX_TASKS(MAX_TASKS),
		.IDX_W(IDX_W)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.task_index(task_index),
		.exec_time(exec_time),
		.task_deadline(task_deadline),
		.running_task(running_task)
	);
endmodule
`default_nettype wire
